>>> src/lusa_pkg.sv
// Package for the least-used slot assigner: operation and result codes,
// stream field widths and the control/status structs.
// No dependencies; every module of the block imports it.
package lusa_pkg;

    localparam int OP_W = 2;
    localparam int REQ_W = 16;
    localparam int SLOT_OUT_W = 3;
    localparam int IN_TDATA_W = 24;
    localparam int OUT_TDATA_W = 8;

    localparam logic [OP_W-1:0] OP_ASSIGN = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

    localparam logic [1:0] RES_NONE = 2'd0;
    localparam logic [1:0] RES_FULL = 2'd1;
    localparam logic [1:0] RES_ASSIGN = 2'd2;
    localparam logic [1:0] RES_HIT = 2'd3;

    typedef struct packed {
        logic       start;      // latch requester, rewind table and slot scans
        logic       clear;      // empty the table and zero all use counts
        logic       slot_step;  // compare one use count against the best so far
        logic       append;     // write the new pair and bump its slot count
        logic       issue;      // read the next table entry
        logic       scan;       // compare the returned entry against the requester
        logic       shift_wr;   // write the returned entry one place lower
        logic       remove;     // drop the last entry and decrement the slot count
        logic       finish;     // load the output register
        logic [1:0] res_code;
    } lusa_cmd_t;

    typedef struct packed {
        logic tbl_full;   // table holds ENTRIES pairs
        logic slot_done;  // all use counts have been compared
        logic hit;        // returned entry matches the requester
        logic tbl_done;   // nothing left to read and nothing in flight
        logic out_busy;   // output register holds a result not yet taken
    } lusa_stat_t;

endpackage

>>> src/lusa_ctrl.sv
// Controller of the least-used slot assigner: sequences one request through
// slot scan, table scan and table compaction. Depends on lusa_pkg.
module lusa_ctrl
    import lusa_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [OP_W-1:0] in_op,
    input  lusa_stat_t      stat,
    output logic            in_ready,
    output lusa_cmd_t       cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SLOT = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [1:0] res_reg, res_next;
    logic       release_reg, release_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        res_next = res_reg;
        release_next = release_reg;
        cmd = '0;
        cmd.res_code = res_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_op)
                        OP_ASSIGN:
                        begin
                            if (stat.tbl_full)
                            begin
                                res_next = RES_FULL;
                                state_next = S_RESULT;
                            end
                            else
                            begin
                                cmd.start = 1'b1;
                                state_next = S_SLOT;
                            end
                        end
                        OP_LOOKUP, OP_RELEASE:
                        begin
                            cmd.start = 1'b1;
                            release_next = (in_op == OP_RELEASE);
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            cmd.clear = 1'b1;
                            res_next = RES_NONE;
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end
            S_SLOT:
            begin
                if (stat.slot_done)
                begin
                    cmd.append = 1'b1;
                    res_next = RES_ASSIGN;
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.slot_step = 1'b1;
                end
            end
            S_SCAN:
            begin
                cmd.issue = 1'b1;
                cmd.scan = 1'b1;
                if (stat.hit)
                begin
                    res_next = RES_HIT;
                    state_next = release_reg ? S_SHIFT : S_RESULT;
                end
                else if (stat.tbl_done)
                begin
                    res_next = RES_NONE;
                    state_next = S_RESULT;
                end
            end
            S_SHIFT:
            begin
                cmd.issue = 1'b1;
                cmd.shift_wr = 1'b1;
                if (stat.tbl_done)
                begin
                    cmd.remove = 1'b1;
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            res_reg <= RES_NONE;
            release_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            res_reg <= res_next;
            release_reg <= release_next;
        end
    end

endmodule

>>> src/lusa_dp.sv
// Datapath of the least-used slot assigner: use counts, the pair table
// memory, scan counters and the output register. Depends on lusa_pkg.
module lusa_dp
    import lusa_pkg::*;
#(
    parameter int ENTRIES = 64,
    parameter int SLOTS = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [REQ_W-1:0] in_req,
    input  lusa_cmd_t        cmd,
    output lusa_stat_t       stat,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [SLOT_OUT_W-1:0] out_slot,
    output logic             out_found,
    output logic             out_full
);

    localparam int CW = $clog2(ENTRIES + 1);             // pair count, use counts
    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SIW = $clog2(SLOTS + 1);
    localparam int MW = REQ_W + SW;

    logic [CW-1:0]    use_reg [0:SLOTS-1];
    logic [CW-1:0]    count_reg;
    logic [MW-1:0]    mem [0:ENTRIES-1];
    logic [MW-1:0]    mem_q;
    logic             mem_we;
    logic [AW-1:0]    mem_wa;
    logic [MW-1:0]    mem_wd;
    logic [CW-1:0]    addr_reg;
    logic [CW-1:0]    rd_addr_reg;
    logic             rd_vld_reg;
    logic [REQ_W-1:0] req_reg;
    logic [SIW-1:0]   slot_idx_reg;
    logic [SW-1:0]    best_reg;
    logic [CW-1:0]    best_cnt_reg;
    logic [SW-1:0]    hit_slot_reg;
    logic [CW-1:0]    cur_cnt;
    logic             hit;
    logic             out_valid_reg;
    logic [SLOT_OUT_W-1:0] out_slot_reg;
    logic             out_found_reg;
    logic             out_full_reg;

    assign cur_cnt = use_reg[slot_idx_reg[SW-1:0]];
    assign hit = rd_vld_reg && (mem_q[MW-1:SW] == req_reg);

    assign stat.tbl_full = (count_reg == CW'(ENTRIES));
    assign stat.slot_done = (slot_idx_reg == SIW'(SLOTS));
    assign stat.hit = hit;
    assign stat.tbl_done = !rd_vld_reg && (addr_reg >= count_reg);
    assign stat.out_busy = out_valid_reg && !out_ready;

    // Table memory: one write port, one registered read port.
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = count_reg[AW-1:0];
        mem_wd = {req_reg, best_reg};
        if (cmd.append)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.shift_wr && rd_vld_reg)
        begin
            mem_we = 1'b1;
            mem_wa = AW'(rd_addr_reg - CW'(1));
            mem_wd = mem_q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        mem_q <= mem[addr_reg[AW-1:0]];
    end

    // Table read sequencing, shared by the match scan and the compaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
            rd_addr_reg <= '0;
            rd_vld_reg <= 1'b0;
        end
        else if (cmd.start)
        begin
            addr_reg <= '0;
            rd_vld_reg <= 1'b0;
        end
        else if (cmd.scan && hit)
        begin
            addr_reg <= rd_addr_reg + CW'(1);
            rd_vld_reg <= 1'b0;
        end
        else if (cmd.issue)
        begin
            if (addr_reg < count_reg)
            begin
                rd_addr_reg <= addr_reg;
                addr_reg <= addr_reg + CW'(1);
                rd_vld_reg <= 1'b1;
            end
            else
            begin
                rd_vld_reg <= 1'b0;
            end
        end
    end

    // Use counts and pair count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                use_reg[i] <= '0;
            end
            count_reg <= '0;
        end
        else if (cmd.clear)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                use_reg[i] <= '0;
            end
            count_reg <= '0;
        end
        else if (cmd.append)
        begin
            use_reg[best_reg] <= use_reg[best_reg] + CW'(1);
            count_reg <= count_reg + CW'(1);
        end
        else if (cmd.remove)
        begin
            if (use_reg[hit_slot_reg] != '0)
            begin
                use_reg[hit_slot_reg] <= use_reg[hit_slot_reg] - CW'(1);
            end
            count_reg <= count_reg - CW'(1);
        end
    end

    // Minimum search over the use counts, one slot per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_idx_reg <= '0;
        end
        else if (cmd.start)
        begin
            slot_idx_reg <= SIW'(1);
        end
        else if (cmd.slot_step)
        begin
            slot_idx_reg <= slot_idx_reg + SIW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            req_reg <= in_req;
            best_reg <= '0;
            best_cnt_reg <= use_reg[0];
        end
        else if (cmd.slot_step && (cur_cnt < best_cnt_reg))
        begin
            best_reg <= slot_idx_reg[SW-1:0];
            best_cnt_reg <= cur_cnt;
        end
        if (cmd.scan && hit)
        begin
            hit_slot_reg <= mem_q[SW-1:0];
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            unique case (cmd.res_code)
                RES_ASSIGN: out_slot_reg <= SLOT_OUT_W'(best_reg);
                RES_HIT:    out_slot_reg <= SLOT_OUT_W'(hit_slot_reg);
                default:    out_slot_reg <= '0;
            endcase
            out_found_reg <= (cmd.res_code == RES_ASSIGN) || (cmd.res_code == RES_HIT);
            out_full_reg <= (cmd.res_code == RES_FULL);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_slot = out_slot_reg;
    assign out_found = out_found_reg;
    assign out_full = out_full_reg;

endmodule

>>> src/least_used_slot_assigner.sv
// Top level of the least-used slot assigner: stream ports around the
// controller (lusa_ctrl) and the datapath (lusa_dp). Depends on lusa_pkg.
//
// The block hands out slot numbers so that SLOTS slots are used evenly. Every
// request on the slave stream gives exactly one result on the master stream.
// Assign picks the lowest-numbered slot with the smallest use count, bumps
// that count and appends (requester, slot) to a table of up to ENTRIES pairs
// kept oldest first; when the table is full it answers table_full and changes
// nothing. Lookup returns the slot of the oldest pair for the requester.
// Release removes that pair, keeps the order of the others and decrements the
// slot's use count. Clear empties the table and zeroes all counts. Requests
// are handled one at a time. An assign runs the minimum search, which compares
// one use count per cycle, before it bumps the count and appends the pair. A
// lookup scans the table oldest first, one entry per cycle, because the table
// sits in a memory with a single read port, and stops at the first match. A
// release that matches adds the compaction pass that moves every later pair
// down by one, again one entry per cycle; a release that misses runs the same
// scan as a lookup that misses. Slack on the output side is one register: a
// new request is accepted while a result waits to be taken.
module least_used_slot_assigner
    import lusa_pkg::*;
#(
    parameter int ENTRIES = 64,
    parameter int SLOTS = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // operation [1:0], line_index [17:2], zero padding [23:18]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // slot [2:0], found [3], table_full [4], zero padding [7:5]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    lusa_cmd_t             cmd;
    lusa_stat_t            stat;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  found;
    logic                  table_full;

    // The controller only looks at the stream while idle, so the request
    // fields are taken straight from the port on the accepting edge.
    lusa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (s_axis_tdata[OP_W-1:0]),
        .stat     (stat),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    lusa_dp #(
        .ENTRIES (ENTRIES),
        .SLOTS   (SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_req    (s_axis_tdata[OP_W+REQ_W-1:OP_W]),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_slot  (slot),
        .out_found (found),
        .out_full  (table_full)
    );

    assign m_axis_tdata = {3'b000, table_full, found, slot};

endmodule
